@@ sv/ple_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ple_pkg
// Shared types and constants of the positional list engine.
// ----------------------------------------------------------------------------
package ple_pkg;

    localparam int DEPTH      = 16;
    localparam int DATA_WIDTH = 32;

    localparam int CMD_W  = 3;
    localparam int POS_W  = 5;
    localparam int VAL_W  = 32;
    localparam int LEN_W  = 5;
    localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int CMP_W  = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT  = 3'd0,
        CMD_REMOVE  = 3'd1,
        CMD_GET     = 3'd2,
        CMD_REPLACE = 3'd3,
        CMD_CLEAR   = 3'd4
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_BADPOS = 2'd1,
        ST_FULL   = 2'd2
    } t_status;

    typedef struct packed {
        logic [CMD_W-1:0] command;
        logic [POS_W-1:0] position;
        logic [VAL_W-1:0] value;
    } t_in_item;

    typedef struct packed {
        t_status          status;
        logic [VAL_W-1:0] data;
        logic [LEN_W-1:0] length;
        logic             empty_res;
    } t_out_item;

    typedef struct packed {
        logic             ins;
        logic             rem;
        logic             wr;
        logic [IDX_W-1:0] idx;
    } t_ple_ctl;

endpackage
`default_nettype wire

@@ sv/ple_cell.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ple_cell
// One list slot: loads the new word, takes its left or right neighbor on a
// shift, or holds.
// ----------------------------------------------------------------------------
module ple_cell
    import ple_pkg::*;
(
    input  wire logic                        i_clk,
    input  wire ple_pkg::t_ple_ctl           i_ctl,
    input  wire logic [ple_pkg::IDX_W-1:0]   i_index,
    input  wire logic [ple_pkg::DATA_WIDTH-1:0] i_value,
    input  wire logic [ple_pkg::DATA_WIDTH-1:0] i_left,
    input  wire logic [ple_pkg::DATA_WIDTH-1:0] i_right,
    output logic      [ple_pkg::DATA_WIDTH-1:0] o_entry
);

    logic [DATA_WIDTH-1:0] r_entry;

    always_ff @(posedge i_clk) begin
        priority if (i_ctl.ins && i_index == i_ctl.idx) begin
            r_entry <= i_value;
        end else if (i_ctl.ins && i_index > i_ctl.idx) begin
            r_entry <= i_left;
        end else if (i_ctl.rem && i_index >= i_ctl.idx) begin
            r_entry <= i_right;
        end else if (i_ctl.wr && i_index == i_ctl.idx) begin
            r_entry <= i_value;
        end else begin
            r_entry <= r_entry;
        end
    end

    assign o_entry = r_entry;

endmodule
`default_nettype wire

@@ sv/ple_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ple_ctrl
// Command decode: range and full checks, cell controls and next length.
// ----------------------------------------------------------------------------
module ple_ctrl
    import ple_pkg::*;
(
    input  wire logic                      i_fire,
    input  wire ple_pkg::t_in_item         i_item,
    input  wire logic [ple_pkg::CNT_W-1:0] i_count,
    output ple_pkg::t_ple_ctl              o_ctl,
    output ple_pkg::t_status               o_status,
    output logic                           o_read,
    output logic      [ple_pkg::CNT_W-1:0] o_count
);

    logic [CMP_W-1:0] pos_x;
    logic [CMP_W-1:0] cnt_x;
    logic [POS_W-1:0] pos_m1;
    logic             in_list;
    logic             ins_range;
    logic             full;

    assign pos_x     = CMP_W'(i_item.position);
    assign cnt_x     = CMP_W'(i_count);
    assign pos_m1    = i_item.position - POS_W'(1);
    assign in_list   = (pos_x != '0) && (pos_x <= cnt_x);
    assign ins_range = (pos_x != '0) && (pos_x <= cnt_x + CMP_W'(1));
    assign full      = (cnt_x == CMP_W'(DEPTH));

    always_comb begin
        o_ctl     = '0;
        o_ctl.idx = IDX_W'(pos_m1);
        o_status  = ST_OK;
        o_read    = 1'b0;
        o_count   = i_count;
        unique case (i_item.command)
            CMD_INSERT: begin
                if (!ins_range) begin
                    o_status = ST_BADPOS;
                end else if (full) begin
                    o_status = ST_FULL;
                end else begin
                    o_ctl.ins = i_fire;
                    o_count   = i_count + CNT_W'(1);
                end
            end
            CMD_REMOVE: begin
                if (!in_list) begin
                    o_status = ST_BADPOS;
                end else begin
                    o_ctl.rem = i_fire;
                    o_count   = i_count - CNT_W'(1);
                end
            end
            CMD_GET: begin
                if (!in_list) begin
                    o_status = ST_BADPOS;
                end else begin
                    o_read = 1'b1;
                end
            end
            CMD_REPLACE: begin
                if (!in_list) begin
                    o_status = ST_BADPOS;
                end else begin
                    o_read   = 1'b1;
                    o_ctl.wr = i_fire;
                end
            end
            CMD_CLEAR: begin
                o_count = '0;
            end
            default: begin
                o_count = i_count;
            end
        endcase
    end

endmodule
`default_nettype wire

@@ sv/positional_list_engine.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// positional_list_engine
// Ordered list of up to DEPTH words addressed by 1-based position.
// ----------------------------------------------------------------------------
// Input channel carries one command item (insert, remove, get, replace,
// clear) with position and value; output channel returns one result item
// per command: status, data read, new length and empty flag.
// Each item is done in the cycle it is accepted: the row of cells shifts
// all entries at once, so the result is valid the cycle after acceptance
// and one item per cycle is sustained while the receiver does not stall.
// A single output register holds the result; the input is stalled only
// while that register is full and the receiver stalls, and frees in the
// same cycle the result is taken.
// Reset empties the list (length 0) and drops any pending result; the
// words in the cells are not cleared and are never read before written.
// ----------------------------------------------------------------------------
module positional_list_engine
    import ple_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire ple_pkg::t_in_item  i_in_item,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output ple_pkg::t_out_item      o_out_item
);

    logic [CNT_W-1:0]      r_count;
    logic [CNT_W-1:0]      n_count;
    logic                  r_out_valid;
    t_out_item             r_out;
    logic                  in_fire;
    t_ple_ctl              ctl;
    t_status               status;
    logic                  rd;
    logic [DATA_WIDTH-1:0] value;
    logic [DATA_WIDTH-1:0] entry [DEPTH];
    logic [DATA_WIDTH-1:0] rd_data;

    assign o_in_stall  = r_out_valid && i_out_stall;
    assign in_fire     = i_in_valid && !o_in_stall;
    assign value       = DATA_WIDTH'(i_in_item.value);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    ple_ctrl u_ctrl (
        .i_fire   (in_fire),
        .i_item   (i_in_item),
        .i_count  (r_count),
        .o_ctl    (ctl),
        .o_status (status),
        .o_read   (rd),
        .o_count  (n_count)
    );

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        ple_cell u_cell (
            .i_clk   (i_clk),
            .i_ctl   (ctl),
            .i_index (IDX_W'(g)),
            .i_value (value),
            .i_left  ((g == 0) ? value : entry[(g == 0) ? 0 : g - 1]),
            .i_right ((g == DEPTH - 1) ? entry[g] : entry[(g == DEPTH - 1) ? g : g + 1]),
            .o_entry (entry[g])
        );
    end

    assign rd_data = entry[ctl.idx];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_fire) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_out.status    <= status;
            r_out.data      <= rd ? VAL_W'(rd_data) : '0;
            r_out.length    <= LEN_W'(n_count);
            r_out.empty_res <= (n_count == '0);
        end
    end

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("list length beyond depth");

    a_stall_needs_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> r_out_valid)
        else $error("input stalled with no pending result");

    a_insert_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && ctl.ins) |=> (r_count == $past(r_count) + CNT_W'(1)))
        else $error("insert did not grow the list");

    a_clear_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && i_in_item.command == CMD_CLEAR)
            |=> (r_count == '0 && r_out.empty_res && r_out_valid))
        else $error("clear left entries");
`endif

endmodule
`default_nettype wire

@@ sim/tb_positional_list_engine.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_positional_list_engine
// Self-checking bench for the positional list engine. A short table of list
// commands covers the empty, full and out-of-range cases and the unused
// command codes, then a long run of random commands grows and drains the
// list. A shadow copy of the list predicts each result the table leaves open,
// and results are checked in order while both sides idle and stall at random.
// ----------------------------------------------------------------------------
module tb_positional_list_engine;
    import ple_pkg::*;

    localparam int CLK_HALF      = 5;
    localparam int RESET_CYCLES  = 12;
    localparam int RANDOM_ITEMS  = 550;
    localparam int DRAIN_CYCLES  = 8;
    localparam int CYCLE_LIMIT   = 300000;
    localparam int TABLE_ROWS    = 17;

    localparam logic [CMD_W-1:0] CMD_SPARE_LO = 3'd5;
    localparam logic [CMD_W-1:0] CMD_SPARE_HI = 3'd7;

    typedef struct {
        logic [CMD_W-1:0] command;
        logic [POS_W-1:0] position;
        logic [VAL_W-1:0] value;
        int               repeats;
        bit               typed;
        t_out_item        result;
    } t_cmd_row;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    logic      in_stall;
    t_in_item  in_item   = '0;
    logic      out_valid;
    logic      out_stall = 1'b0;
    t_out_item out_item;

    t_cmd_row  cmd_table [TABLE_ROWS];
    t_out_item expected_results [$];
    t_out_item want;

    logic [DATA_WIDTH-1:0] list_words [DEPTH];
    int          list_len      = 0;
    bit          growing       = 1'b1;
    int unsigned cycle_count   = 0;
    int          fail_count    = 0;
    int          items_sent    = 0;
    int          results_seen  = 0;
    int          ok_count      = 0;
    int          badpos_count  = 0;
    int          full_count    = 0;
    int          peak_len      = 0;

    positional_list_engine DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (out_item)
    );

    always #CLK_HALF clk = ~clk;

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
    end

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("Timed out after %0d cycles with %0d results outstanding",
                 cycle_count, expected_results.size());
        $display("FAIL");
        $finish;
    end

    function automatic t_out_item list_apply(input t_in_item item);
        t_out_item res;
        int        pos;
        int        i;
        res.status = ST_OK;
        res.data   = '0;
        pos        = int'(item.position);
        case (item.command)
            CMD_INSERT: begin
                if (pos < 1 || pos > list_len + 1) begin
                    res.status = ST_BADPOS;
                end else if (list_len >= DEPTH) begin
                    res.status = ST_FULL;
                end else begin
                    for (i = list_len; i > pos - 1; i--) begin
                        list_words[i] = list_words[i - 1];
                    end
                    list_words[pos - 1] = item.value[DATA_WIDTH-1:0];
                    list_len++;
                end
            end
            CMD_REMOVE: begin
                if (pos < 1 || pos > list_len) begin
                    res.status = ST_BADPOS;
                end else begin
                    for (i = pos - 1; i + 1 < list_len; i++) begin
                        list_words[i] = list_words[i + 1];
                    end
                    list_len--;
                end
            end
            CMD_GET: begin
                if (pos < 1 || pos > list_len) begin
                    res.status = ST_BADPOS;
                end else begin
                    res.data = VAL_W'(list_words[pos - 1]);
                end
            end
            CMD_REPLACE: begin
                if (pos < 1 || pos > list_len) begin
                    res.status = ST_BADPOS;
                end else begin
                    res.data = VAL_W'(list_words[pos - 1]);
                    list_words[pos - 1] = item.value[DATA_WIDTH-1:0];
                end
            end
            CMD_CLEAR: begin
                list_len = 0;
            end
            default: begin
            end
        endcase
        res.length    = LEN_W'(list_len);
        res.empty_res = (list_len == 0);
        return res;
    endfunction

    function automatic int pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 50) begin
            return 0;
        end else if (r < 85) begin
            return $urandom_range(1, 3);
        end else if (r < 97) begin
            return $urandom_range(4, 10);
        end
        return $urandom_range(20, 40);
    endfunction

    function automatic logic [VAL_W-1:0] pick_value();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r == 0) begin
            return '0;
        end else if (r == 1) begin
            return '1;
        end
        return $urandom();
    endfunction

    // Mostly well-formed commands at legal positions, steered to fill and
    // drain the list; the rest is clears, unused codes and wild positions.
    function automatic t_in_item make_random_item();
        t_in_item    item;
        int unsigned r;
        int          ins_cut;
        item.value    = pick_value();
        item.position = POS_W'($urandom_range(0, 31));
        if (growing && list_len == DEPTH && $urandom_range(0, 1) == 1) begin
            growing = 1'b0;
        end else if (!growing && list_len == 0) begin
            growing = 1'b1;
        end
        r = $urandom_range(0, 99);
        if (r < 2) begin
            item.command = CMD_CLEAR;
        end else if (r < 5) begin
            item.command = CMD_W'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI));
        end else if (r < 12) begin
            item.command = CMD_W'($urandom_range(CMD_INSERT, CMD_REPLACE));
        end else begin
            ins_cut = growing ? 55 : 15;
            r = $urandom_range(0, 99);
            if (list_len == 0 || r < ins_cut) begin
                item.command  = CMD_INSERT;
                item.position = POS_W'($urandom_range(1, list_len + 1));
            end else begin
                if (r < 70) begin
                    item.command = CMD_REMOVE;
                end else if (r < 85) begin
                    item.command = CMD_GET;
                end else begin
                    item.command = CMD_REPLACE;
                end
                item.position = POS_W'($urandom_range(1, list_len));
            end
        end
        return item;
    endfunction

    // Call at a falling edge; returns at the falling edge after acceptance.
    task automatic send_item(input t_in_item item, input bit typed,
                             input t_out_item typed_res);
        t_out_item predicted;
        int        gap;
        gap = pick_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_item  <= item;
        in_valid <= 1'b1;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        predicted = list_apply(item);
        expected_results.push_back(typed ? typed_res : predicted);
        items_sent++;
        @(negedge clk);
    endtask

    initial begin
        int unsigned r;
        int          hold_left;
        bit          stall_mode;
        hold_left  = 0;
        stall_mode = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_left == 0) begin
                r = $urandom_range(0, 99);
                if (r < 55) begin
                    stall_mode = 1'b0;
                    hold_left  = $urandom_range(1, 6);
                end else if (r < 85) begin
                    stall_mode = 1'b1;
                    hold_left  = $urandom_range(1, 3);
                end else if (r < 95) begin
                    stall_mode = 1'b1;
                    hold_left  = $urandom_range(4, 20);
                end else begin
                    stall_mode = 1'b0;
                    hold_left  = $urandom_range(30, 90);
                end
            end
            hold_left--;
            out_stall <= stall_mode;
        end
    end

    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall) begin
            if (expected_results.size() == 0) begin
                $error("result item with nothing expected: status %0d data %h length %0d",
                       out_item.status, out_item.data, out_item.length);
                fail_count++;
            end else begin
                want = expected_results.pop_front();
                results_seen++;
                if (out_item.status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, out_item.status);
                    fail_count++;
                end
                if (out_item.data !== want.data) begin
                    $error("data: expected %h, got %h", want.data, out_item.data);
                    fail_count++;
                end
                if (out_item.length !== want.length) begin
                    $error("length: expected %0d, got %0d", want.length, out_item.length);
                    fail_count++;
                end
                if (out_item.empty_res !== want.empty_res) begin
                    $error("empty_res: expected %0d, got %0d",
                           want.empty_res, out_item.empty_res);
                    fail_count++;
                end
                case (want.status)
                    ST_OK:     ok_count++;
                    ST_BADPOS: badpos_count++;
                    default:   full_count++;
                endcase
                if (int'(want.length) > peak_len) begin
                    peak_len = int'(want.length);
                end
            end
        end
    end

    initial begin
        t_in_item item;
        int       row;
        int       k;
        int       n;

        cmd_table = '{
            '{CMD_GET,      5'd31, 32'h0000_0000,  1, 1'b1, '{ST_BADPOS, 32'h0, 5'd0,  1'b1}},
            '{CMD_REMOVE,   5'd0,  32'h0000_0000,  1, 1'b1, '{ST_BADPOS, 32'h0, 5'd0,  1'b1}},
            '{CMD_INSERT,   5'd2,  32'h0000_0000,  1, 1'b1, '{ST_BADPOS, 32'h0, 5'd0,  1'b1}},
            '{CMD_REPLACE,  5'd1,  32'hDEAD_BEEF,  1, 1'b1, '{ST_BADPOS, 32'h0, 5'd0,  1'b1}},
            '{CMD_CLEAR,    5'd0,  32'h0000_0000,  1, 1'b1, '{ST_OK,     32'h0, 5'd0,  1'b1}},
            '{CMD_INSERT,   5'd1,  32'hFFFF_FFFF,  1, 1'b1, '{ST_OK,     32'h0, 5'd1,  1'b0}},
            '{CMD_INSERT,   5'd2,  32'h0000_0000,  1, 1'b1, '{ST_OK,     32'h0, 5'd2,  1'b0}},
            '{CMD_INSERT,   5'd1,  32'h1000_0000, 14, 1'b0, '{ST_OK,     32'h0, 5'd0,  1'b0}},
            '{CMD_INSERT,   5'd17, 32'h1234_5678,  1, 1'b1, '{ST_FULL,   32'h0, 5'd16, 1'b0}},
            '{CMD_INSERT,   5'd18, 32'h0000_0000,  1, 1'b1, '{ST_BADPOS, 32'h0, 5'd16, 1'b0}},
            '{CMD_GET,      5'd16, 32'h0000_0000,  1, 1'b0, '{ST_OK,     32'h0, 5'd0,  1'b0}},
            '{CMD_REPLACE,  5'd16, 32'h8000_0001,  1, 1'b0, '{ST_OK,     32'h0, 5'd0,  1'b0}},
            '{CMD_REMOVE,   5'd16, 32'h0000_0000,  1, 1'b0, '{ST_OK,     32'h0, 5'd0,  1'b0}},
            '{CMD_REMOVE,   5'd1,  32'h0000_0000,  1, 1'b0, '{ST_OK,     32'h0, 5'd0,  1'b0}},
            '{CMD_SPARE_LO, 5'd7,  32'hAAAA_5555,  1, 1'b1, '{ST_OK,     32'h0, 5'd14, 1'b0}},
            '{CMD_SPARE_HI, 5'd31, 32'hFFFF_FFFF,  1, 1'b1, '{ST_OK,     32'h0, 5'd14, 1'b0}},
            '{CMD_CLEAR,    5'd31, 32'h0000_0000,  1, 1'b1, '{ST_OK,     32'h0, 5'd0,  1'b1}}
        };

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (row = 0; row < TABLE_ROWS; row++) begin
            for (k = 0; k < cmd_table[row].repeats; k++) begin
                item.command  = cmd_table[row].command;
                item.position = cmd_table[row].position;
                item.value    = cmd_table[row].value + VAL_W'(k);
                send_item(item, cmd_table[row].typed, cmd_table[row].result);
            end
        end

        for (n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == RANDOM_ITEMS / 2) begin
                // hold the sender until every result is back
                in_valid <= 1'b0;
                while (expected_results.size() != 0) @(posedge clk);
                @(negedge clk);
            end
            item = make_random_item();
            send_item(item, 1'b0, '0);
        end

        in_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d command items, checked %0d results in %0d cycles",
                 items_sent, results_seen, cycle_count);
        $display("Status mix: %0d ok, %0d bad position, %0d list full; peak length %0d",
                 ok_count, badpos_count, full_count, peak_len);
        if (fail_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
sv/ple_pkg.sv
sv/ple_cell.sv
sv/ple_ctrl.sv
sv/positional_list_engine.sv
sim/tb_positional_list_engine.sv
